// ===== hw/rtl/acr_pkg.sv =====
package acr_pkg;

  localparam int TableEntries = 16;
  localparam int IdxW         = $clog2(TableEntries);
  localparam int MaxResults   = 16;
  localparam int CntW         = $clog2(MaxResults + 1);
  localparam int QDepth       = 4;
  localparam int QPtrW        = $clog2(QDepth);

  localparam logic [2:0] REG_MY_IP         = 3'd0;
  localparam logic [2:0] REG_MY_MAC        = 3'd1;
  localparam logic [2:0] REG_RETRY_TIMEOUT = 3'd2;
  localparam logic [2:0] REG_RETRY_LIMIT   = 3'd3;
  localparam logic [2:0] REG_CACHE_TIMEOUT = 3'd4;
  localparam logic [2:0] REG_PROXY_ENABLE  = 3'd5;

  localparam logic [15:0] OP_REQUEST = 16'd1;
  localparam logic [15:0] OP_REPLY   = 16'd2;

  localparam logic [47:0] MAC_BCAST = 48'hFFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    FN_TICK    = 2'd0,
    FN_FRAME   = 2'd1,
    FN_RESOLVE = 2'd2,
    FN_REVERSE = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    FK_NONE    = 2'd0,
    FK_REQUEST = 2'd1,
    FK_REPLY   = 2'd2
  } frame_kind_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_SENDER  = 3'd1,
    ST_UNSUPPORTED = 3'd2,
    ST_TABLE_FULL  = 3'd3,
    ST_FAILED      = 3'd4
  } status_t;

  typedef struct packed {
    logic [31:0] my_ip;
    logic [47:0] my_mac;
    logic [15:0] retry_timeout;
    logic [7:0]  retry_limit;
    logic [31:0] cache_timeout;
    logic        proxy_enable;
  } cfg_t;

  // one classified item as it waits for the engine
  typedef struct packed {
    func_t       func;
    logic [31:0] key_ip;
    logic [47:0] key_mac;
    logic [31:0] tip;
    logic        bad;
    logic        recog;
    logic        op_req;
    logic        op_other;
  } q_entry_t;

  typedef struct packed {
    frame_kind_t kind;
    logic [47:0] dest_mac;
    logic [31:0] sender_ip;
    logic [47:0] sender_mac;
    logic [31:0] target_ip;
    logic [47:0] target_mac;
    logic        aval;
    logic [47:0] amac;
    logic [31:0] aip;
    status_t     status;
  } res_t;

endpackage

// ===== hw/rtl/acr_queue.sv =====
module acr_queue
  import acr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t din,
  output logic     full,
  input  logic     pop,
  output q_entry_t dout,
  output logic     empty
);

  q_entry_t         mem_r [QDepth];
  logic [QPtrW-1:0] wr_r;
  logic [QPtrW-1:0] rd_r;
  logic [QPtrW:0]   cnt_r;

  assign full  = (cnt_r == (QPtrW+1)'(QDepth));
  assign empty = (cnt_r == '0);
  assign dout  = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= din;
    end
  end

endmodule

// ===== hw/rtl/acr_engine.sv =====
module acr_engine
  import acr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     q_empty,
  input  q_entry_t q_dout,
  output logic     q_pop,
  output logic     out_valid,
  input  logic     out_ready,
  output res_t     out_res,
  output logic     out_last
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DECIDE, S_FLUSH} state_t;

  state_t          state_r;
  q_entry_t        item_r;
  logic [IdxW-1:0] idx_r;
  logic [CntW-1:0] cnt_r;
  logic            hit_r;
  logic [IdxW-1:0] hit_idx_r;
  logic            free_v_r;
  logic [IdxW-1:0] free_idx_r;
  logic            best_v_r;
  logic [31:0]     best_ip_r;
  res_t            hold_r;
  logic            hold_v_r;
  res_t            out_r;
  logic            out_v_r;
  logic            out_last_r;
  logic [31:0]     tick_now_r;

  logic        slot_valid_r   [TableEntries];
  logic        slot_pending_r [TableEntries];
  logic [31:0] slot_ip_r      [TableEntries];
  logic [47:0] slot_mac_r     [TableEntries];
  logic [31:0] slot_stamp_r   [TableEntries];
  logic [7:0]  slot_tries_r   [TableEntries];

  logic        out_free;
  logic        out_load;
  logic [31:0] age;
  logic        fresh_i;
  logic        due;
  logic [7:0]  tries_inc;
  logic        stall;
  logic        last_idx;
  logic        cand;
  logic        hit_fresh;
  res_t        tick_res;
  res_t        dec_res;

  assign out_free  = !out_v_r || out_ready;
  assign age       = tick_now_r - slot_stamp_r[idx_r];
  assign fresh_i   = (age <= cfg.cache_timeout);
  assign due       = slot_valid_r[idx_r] && slot_pending_r[idx_r] &&
                     (age >= {16'd0, cfg.retry_timeout});
  assign tries_inc = slot_tries_r[idx_r] + 8'd1;
  assign stall     = (item_r.func == FN_TICK) && due && hold_v_r && !out_free;
  assign last_idx  = (idx_r == IdxW'(TableEntries - 1));
  assign cand      = !item_r.bad && slot_valid_r[idx_r] && !slot_pending_r[idx_r] &&
                     (slot_mac_r[idx_r] == item_r.key_mac) && fresh_i;
  assign hit_fresh = ((tick_now_r - slot_stamp_r[hit_idx_r]) <= cfg.cache_timeout);
  assign q_pop     = (state_r == S_IDLE) && !q_empty;
  // a beat goes into the output register this cycle
  assign out_load  = ((state_r == S_SCAN) && (item_r.func == FN_TICK) && !stall && due &&
                      hold_v_r) ||
                     ((state_r == S_FLUSH) && hold_v_r && out_free);

  assign out_valid = out_v_r;
  assign out_res   = out_r;
  assign out_last  = out_last_r;

  always_comb begin
    tick_res = '0;
    if (tries_inc < cfg.retry_limit) begin
      tick_res.kind       = FK_REQUEST;
      tick_res.dest_mac   = MAC_BCAST;
      tick_res.sender_ip  = cfg.my_ip;
      tick_res.sender_mac = cfg.my_mac;
      tick_res.target_ip  = slot_ip_r[idx_r];
    end else begin
      tick_res.target_ip = slot_ip_r[idx_r];
      tick_res.status    = ST_FAILED;
    end
  end

  always_comb begin
    dec_res = '0;
    unique case (item_r.func)
      FN_FRAME: begin
        if (item_r.bad) begin
          dec_res.status = ST_BAD_SENDER;
        end else if (item_r.recog) begin
          if (item_r.op_req) begin
            dec_res.kind       = FK_REPLY;
            dec_res.dest_mac   = item_r.key_mac;
            dec_res.sender_ip  = item_r.tip;
            dec_res.sender_mac = cfg.my_mac;
            dec_res.target_ip  = item_r.key_ip;
            dec_res.target_mac = item_r.key_mac;
          end
          if (!hit_r && !free_v_r) begin
            dec_res.status = ST_TABLE_FULL;
          end else if (item_r.op_other) begin
            dec_res.status = ST_UNSUPPORTED;
          end
        end
      end
      FN_RESOLVE: begin
        if (!hit_r && !free_v_r) begin
          dec_res.status = ST_TABLE_FULL;
        end else if (hit_r && slot_pending_r[hit_idx_r]) begin
          dec_res = '0;
        end else if (hit_r && hit_fresh) begin
          dec_res.aval = 1'b1;
          dec_res.amac = slot_mac_r[hit_idx_r];
        end else begin
          dec_res.kind       = FK_REQUEST;
          dec_res.dest_mac   = MAC_BCAST;
          dec_res.sender_ip  = cfg.my_ip;
          dec_res.sender_mac = cfg.my_mac;
          dec_res.target_ip  = item_r.key_ip;
        end
      end
      FN_REVERSE: begin
        if (best_v_r) begin
          dec_res.aval = 1'b1;
          dec_res.aip  = best_ip_r;
        end
      end
      default: dec_res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      hold_v_r   <= 1'b0;
      out_v_r    <= 1'b0;
      tick_now_r <= '0;
      for (int i = 0; i < TableEntries; i++) begin
        slot_valid_r[i]   <= 1'b0;
        slot_pending_r[i] <= 1'b0;
      end
    end else begin
      if (out_ready && !out_load) begin
        out_v_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            item_r   <= q_dout;
            idx_r    <= '0;
            cnt_r    <= '0;
            hit_r    <= 1'b0;
            free_v_r <= 1'b0;
            best_v_r <= 1'b0;
            if (q_dout.func == FN_TICK) begin
              tick_now_r <= tick_now_r + 32'd1;
            end
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (item_r.func == FN_TICK) begin
            if (!stall) begin
              idx_r <= idx_r + 1'b1;
              if (due) begin
                slot_tries_r[idx_r] <= tries_inc;
                if (tries_inc < cfg.retry_limit) begin
                  slot_stamp_r[idx_r] <= tick_now_r;
                end else begin
                  slot_valid_r[idx_r]   <= 1'b0;
                  slot_pending_r[idx_r] <= 1'b0;
                end
                // previous result is not the final one, send it on
                if (hold_v_r) begin
                  out_r      <= hold_r;
                  out_last_r <= 1'b0;
                  out_v_r    <= 1'b1;
                end
                hold_r   <= tick_res;
                hold_v_r <= 1'b1;
                cnt_r    <= cnt_r + 1'b1;
                if (last_idx || (cnt_r == CntW'(MaxResults - 1))) begin
                  state_r <= S_FLUSH;
                end
              end else if (last_idx) begin
                state_r <= S_FLUSH;
              end
            end
          end else begin
            idx_r <= idx_r + 1'b1;
            if (slot_valid_r[idx_r] && (slot_ip_r[idx_r] == item_r.key_ip) && !hit_r) begin
              hit_r     <= 1'b1;
              hit_idx_r <= idx_r;
            end
            if (!slot_valid_r[idx_r] && !free_v_r) begin
              free_v_r   <= 1'b1;
              free_idx_r <= idx_r;
            end
            if (cand && (!best_v_r || (slot_ip_r[idx_r] < best_ip_r))) begin
              best_v_r  <= 1'b1;
              best_ip_r <= slot_ip_r[idx_r];
            end
            if (last_idx) begin
              state_r <= S_DECIDE;
            end
          end
        end
        S_DECIDE: begin
          hold_r   <= dec_res;
          hold_v_r <= 1'b1;
          state_r  <= S_FLUSH;
          if (item_r.func == FN_FRAME && !item_r.bad) begin
            if (hit_r) begin
              slot_pending_r[hit_idx_r] <= 1'b0;
              slot_tries_r[hit_idx_r]   <= '0;
              slot_mac_r[hit_idx_r]     <= item_r.key_mac;
              slot_stamp_r[hit_idx_r]   <= tick_now_r;
            end else if (item_r.recog && free_v_r) begin
              slot_valid_r[free_idx_r]   <= 1'b1;
              slot_pending_r[free_idx_r] <= 1'b0;
              slot_ip_r[free_idx_r]      <= item_r.key_ip;
              slot_tries_r[free_idx_r]   <= '0;
              slot_mac_r[free_idx_r]     <= item_r.key_mac;
              slot_stamp_r[free_idx_r]   <= tick_now_r;
            end
          end else if (item_r.func == FN_RESOLVE) begin
            if (dec_res.kind == FK_REQUEST) begin
              slot_valid_r[hit_r ? hit_idx_r : free_idx_r]   <= 1'b1;
              slot_pending_r[hit_r ? hit_idx_r : free_idx_r] <= 1'b1;
              slot_ip_r[hit_r ? hit_idx_r : free_idx_r]      <= item_r.key_ip;
              slot_mac_r[hit_r ? hit_idx_r : free_idx_r]     <= '0;
              slot_tries_r[hit_r ? hit_idx_r : free_idx_r]   <= '0;
              slot_stamp_r[hit_r ? hit_idx_r : free_idx_r]   <= tick_now_r;
            end
          end
        end
        S_FLUSH: begin
          if (!hold_v_r) begin
            state_r <= S_IDLE;
          end else if (out_free) begin
            out_r      <= hold_r;
            out_last_r <= 1'b1;
            out_v_r    <= 1'b1;
            hold_v_r   <= 1'b0;
            state_r    <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/arp_cache_resolver.sv =====
// ARP resolver for one interface with a 16-slot IPv4-to-MAC table. Items enter on
// the in_ stream (in_tuser selects tick, received frame, resolve or reverse query),
// are classified and queued in a four-deep queue, and a back-end engine walks the
// table one slot per clock while the out_ stream does not stall a tick. Frames,
// resolve and reverse queries hold the engine while it takes the item from the
// queue, scans all 16 slots, decides and loads the output register; a tick holds
// it while it takes the item, scans with its beats sent during the scan and
// flushes, longer if the out_ stream stalls. Every item except a tick gives exactly
// one beat with out_tlast set; a tick gives zero to sixteen beats.
// Configuration registers sit on the cfg_ port at byte address 8*index.
module arp_cache_resolver
  import acr_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // sender_ip, sender_mac, target_ip, opcode, target_is_local,
  // proxy_route_elsewhere, lookup_ip, lookup_mac
  input  logic [215:0] in_tdata,
  // func
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // frame_dest_mac, frame_sender_ip, frame_sender_mac, frame_target_ip,
  // frame_target_mac, answer_valid, answer_mac, answer_ip, status
  output logic [295:0] out_tdata,
  // frame_kind
  output logic [1:0]   out_tuser,
  output logic         out_tlast,
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [5:0]   cfg_paddr,
  input  logic [63:0]  cfg_pwdata,
  output logic [63:0]  cfg_prdata,
  output logic         cfg_pready
);

  cfg_t     cfg_r;
  q_entry_t q_din;
  q_entry_t q_dout;
  logic     q_full;
  logic     q_empty;
  logic     q_pop;
  logic     push;
  res_t     res;
  logic     wr_en;

  logic [31:0] sip;
  logic [47:0] smac;
  logic [15:0] op;
  func_t       fn;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.my_ip         <= '0;
      cfg_r.my_mac        <= '0;
      cfg_r.retry_timeout <= 16'd1000;
      cfg_r.retry_limit   <= 8'd3;
      cfg_r.cache_timeout <= 32'd120000;
      cfg_r.proxy_enable  <= 1'b0;
    end else if (wr_en) begin
      unique case (cfg_paddr[5:3])
        REG_MY_IP:         cfg_r.my_ip         <= cfg_pwdata[31:0];
        REG_MY_MAC:        cfg_r.my_mac        <= cfg_pwdata[47:0];
        REG_RETRY_TIMEOUT: cfg_r.retry_timeout <= cfg_pwdata[15:0];
        REG_RETRY_LIMIT:   cfg_r.retry_limit   <= cfg_pwdata[7:0];
        REG_CACHE_TIMEOUT: cfg_r.cache_timeout <= cfg_pwdata[31:0];
        REG_PROXY_ENABLE:  cfg_r.proxy_enable  <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[5:3])
      REG_MY_IP:         cfg_prdata = {32'd0, cfg_r.my_ip};
      REG_MY_MAC:        cfg_prdata = {16'd0, cfg_r.my_mac};
      REG_RETRY_TIMEOUT: cfg_prdata = {48'd0, cfg_r.retry_timeout};
      REG_RETRY_LIMIT:   cfg_prdata = {56'd0, cfg_r.retry_limit};
      REG_CACHE_TIMEOUT: cfg_prdata = {32'd0, cfg_r.cache_timeout};
      REG_PROXY_ENABLE:  cfg_prdata = {63'd0, cfg_r.proxy_enable};
      default:           cfg_prdata = '0;
    endcase
  end

  // front: classify the beat before it is queued
  assign fn   = func_t'(in_tuser);
  assign sip  = in_tdata[31:0];
  assign smac = in_tdata[79:32];
  assign op   = in_tdata[127:112];

  always_comb begin
    q_din          = '0;
    q_din.func     = fn;
    q_din.tip      = in_tdata[111:80];
    q_din.op_req   = (op == OP_REQUEST);
    q_din.op_other = (op != OP_REQUEST) && (op != OP_REPLY);
    q_din.recog    = in_tdata[128] || (cfg_r.proxy_enable && in_tdata[129]);
    unique case (fn)
      FN_RESOLVE: begin
        q_din.key_ip = in_tdata[161:130];
      end
      FN_REVERSE: begin
        q_din.key_mac = in_tdata[209:162];
        q_din.bad     = (in_tdata[209:162] == 48'd0);
      end
      default: begin
        q_din.key_ip  = sip;
        q_din.key_mac = smac;
        q_din.bad     = (sip == 32'd0) || (smac == 48'd0);
      end
    endcase
  end

  assign in_tready = !q_full;
  assign push      = in_tvalid && !q_full;

  acr_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  acr_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_empty   (q_empty),
    .q_dout    (q_dout),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res),
    .out_last  (out_tlast)
  );

  assign out_tuser = res.kind;
  assign out_tdata = {4'd0, res.status, res.aip, res.amac, res.aval, res.target_mac,
                      res.target_ip, res.sender_mac, res.sender_ip, res.dest_mac};

endmodule
